/* hdl/tnm_pkg.sv */
// shared constants, types and helpers of the tiling normal-map generator
`default_nettype none
package tnm_pkg;

	// image store geometry
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(DEPTH);

	// field widths
	localparam int COORD_W = 8;
	localparam int CHAN_W  = 8;
	localparam int DIM_W   = 9;
	localparam int LIGHT_W = 9;
	localparam int SLOPE_W = 8;

	// clamp limits of the size registers
	localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

	// flat slope and the bias of the central difference
	localparam logic [SLOPE_W-1:0] SLOPE_FLAT = SLOPE_W'(128);
	localparam logic [LIGHT_W:0]   SLOPE_BIAS = (LIGHT_W + 1)'(510);

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LEFT,
		S_RIGHT,
		S_UP,
		S_DOWN,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		NB_LEFT,
		NB_RIGHT,
		NB_UP,
		NB_DOWN
	} nbr_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic rd_en;
		nbr_t nbr;
		logic cap_a;
		logic cap_nx;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic query;
		logic bad;
	} status_t;

	// floor((a - b + 510) / 4)
	function automatic logic [SLOPE_W-1:0] slope(input logic [LIGHT_W-1:0] a,
		input logic [LIGHT_W-1:0] b);
		logic [LIGHT_W:0] s;
		s = {1'b0, a} + SLOPE_BIAS - {1'b0, b};
		return s[LIGHT_W:2];
	endfunction

endpackage
`default_nettype wire

/* hdl/tnm_ctrl.sv */
// controller state machine: item handshake, neighbour read sequence, result register valid
`default_nettype none
module tnm_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire                 out_stall,
	input  tnm_pkg::status_t    status,
	output tnm_pkg::cmd_t       cmd
);
	import tnm_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && status.query) begin
					state_next = status.bad ? S_DONE : S_LEFT;
				end
			end
			S_LEFT:  state_next = S_RIGHT;
			S_RIGHT: state_next = S_UP;
			S_UP:    state_next = S_DOWN;
			S_DOWN:  state_next = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		cmd.nbr = NB_LEFT;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
			end
			S_LEFT: begin
				cmd.rd_en = 1'b1;
				cmd.nbr   = NB_LEFT;
			end
			S_RIGHT: begin
				cmd.rd_en = 1'b1;
				cmd.nbr   = NB_RIGHT;
				cmd.cap_a = 1'b1;
			end
			S_UP: begin
				cmd.rd_en  = 1'b1;
				cmd.nbr    = NB_UP;
				cmd.cap_nx = 1'b1;
			end
			S_DOWN: begin
				cmd.rd_en = 1'b1;
				cmd.nbr   = NB_DOWN;
				cmd.cap_a = 1'b1;
			end
			S_DONE: begin
				cmd.load_out = out_free;
			end
			default: cmd = '0;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

/* hdl/tnm_dp.sv */
// datapath: size registers, lightness store, neighbour addressing and slope arithmetic
`default_nettype none
module tnm_dp (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_write,
	input  wire                             cfg_index,
	input  wire  [tnm_pkg::DIM_W-1:0]       cfg_data,
	input  wire                             operation,
	input  wire  [tnm_pkg::COORD_W-1:0]     pixel_x,
	input  wire  [tnm_pkg::COORD_W-1:0]     pixel_y,
	input  wire  [tnm_pkg::CHAN_W-1:0]      red,
	input  wire  [tnm_pkg::CHAN_W-1:0]      green,
	input  wire  [tnm_pkg::CHAN_W-1:0]      blue,
	input  tnm_pkg::cmd_t                   cmd,
	output tnm_pkg::status_t                status,
	output logic [tnm_pkg::SLOPE_W-1:0]     normal_x,
	output logic [tnm_pkg::SLOPE_W-1:0]     normal_y,
	output logic                            bad_coordinate
);
	import tnm_pkg::*;

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [DIM_W-1:0]   w_eff;
	logic [DIM_W-1:0]   h_eff;
	logic [DIM_W-1:0]   w_m1;
	logic [DIM_W-1:0]   h_m1;
	logic [CHAN_W-1:0]  mn;
	logic [CHAN_W-1:0]  mx;
	logic [LIGHT_W-1:0] light;
	logic               in_bad;
	logic               wr_en;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic               bad_q;
	logic [COORD_W-1:0] xl;
	logic [COORD_W-1:0] xr;
	logic [COORD_W-1:0] yu;
	logic [COORD_W-1:0] yd;
	logic [COORD_W-1:0] rd_x;
	logic [COORD_W-1:0] rd_y;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ADDR_W-1:0]  mem_addr;
	logic [LIGHT_W-1:0] rdata_q;
	logic [LIGHT_W-1:0] a_q;
	logic [SLOPE_W-1:0] nx_q;
	logic [SLOPE_W-1:0] nx_out_q;
	logic [SLOPE_W-1:0] ny_out_q;
	logic               bad_out_q;
	logic [LIGHT_W-1:0] mem [DEPTH];

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= MAX_W_DIM;
			height_q <= MAX_H_DIM;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default:    width_q  <= width_q;
			endcase
		end
	end

	// effective size, zero taken as one and clamped to the store
	always_comb begin
		if (width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (width_q > MAX_W_DIM) begin
			w_eff = MAX_W_DIM;
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (height_q > MAX_H_DIM) begin
			h_eff = MAX_H_DIM;
		end else begin
			h_eff = height_q;
		end
		w_m1 = w_eff - DIM_W'(1);
		h_m1 = h_eff - DIM_W'(1);
	end

	// lightness of the incoming pixel: min + max of the channels
	always_comb begin
		mn = red;
		mx = red;
		if (green < mn) mn = green;
		if (blue  < mn) mn = blue;
		if (green > mx) mx = green;
		if (blue  > mx) mx = blue;
		light = {1'b0, mn} + {1'b0, mx};
	end

	// range check of the incoming coordinate
	assign in_bad       = ({1'b0, pixel_x} >= w_eff) || ({1'b0, pixel_y} >= h_eff);
	assign status.query = (operation == OP_QUERY);
	assign status.bad   = in_bad;
	assign wr_en        = cmd.accept && (operation == OP_WRITE) && !in_bad;

	// held query coordinate
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q   <= pixel_x;
			y_q   <= pixel_y;
			bad_q <= in_bad;
		end
	end

	// toroidal neighbours
	always_comb begin
		xl = (x_q == '0) ? w_m1[COORD_W-1:0] : x_q - COORD_W'(1);
		xr = (({1'b0, x_q} + DIM_W'(1)) == w_eff) ? '0 : x_q + COORD_W'(1);
		yu = (y_q == '0) ? h_m1[COORD_W-1:0] : y_q - COORD_W'(1);
		yd = (({1'b0, y_q} + DIM_W'(1)) == h_eff) ? '0 : y_q + COORD_W'(1);
	end

	// neighbour select
	always_comb begin
		unique case (cmd.nbr)
			NB_LEFT: begin
				rd_x = xl;
				rd_y = y_q;
			end
			NB_RIGHT: begin
				rd_x = xr;
				rd_y = y_q;
			end
			NB_UP: begin
				rd_x = x_q;
				rd_y = yu;
			end
			NB_DOWN: begin
				rd_x = x_q;
				rd_y = yd;
			end
			default: begin
				rd_x = x_q;
				rd_y = y_q;
			end
		endcase
	end

	// row-major store address, single port
	assign wr_addr  = ADDR_W'(int'(pixel_y) * MAX_WIDTH + int'(pixel_x));
	assign rd_addr  = ADDR_W'(int'(rd_y) * MAX_WIDTH + int'(rd_x));
	assign mem_addr = cmd.accept ? wr_addr : rd_addr;

	// lightness store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[mem_addr] <= light;
		end else if (cmd.rd_en) begin
			rdata_q <= mem[mem_addr];
		end
	end

	// first operand of each difference and the horizontal slope
	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			a_q <= rdata_q;
		end
		if (cmd.cap_nx) begin
			nx_q <= slope(a_q, rdata_q);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (bad_q) begin
				nx_out_q  <= SLOPE_FLAT;
				ny_out_q  <= SLOPE_FLAT;
				bad_out_q <= 1'b1;
			end else begin
				nx_out_q  <= nx_q;
				ny_out_q  <= slope(a_q, rdata_q);
				bad_out_q <= 1'b0;
			end
		end
	end

	assign normal_x       = nx_out_q;
	assign normal_y       = ny_out_q;
	assign bad_coordinate = bad_out_q;

endmodule
`default_nettype wire

/* hdl/tiling_normal_map_generator.sv */
// tiling normal-map generator: top level joining controller and datapath
// a write item is taken while the controller is idle and the next item can follow at once
// a query reads four neighbours one after another through the single store port
// (S_LEFT to S_DOWN); S_DONE loads the result when free and the next item waits for S_IDLE
// an out-of-image query goes straight to S_DONE and reports a flat normal
// arst_n clears control and sets both sizes to 256; the store holds nothing until written
`default_nettype none
module tiling_normal_map_generator (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_write,
	input  wire                             cfg_index,
	input  wire  [tnm_pkg::DIM_W-1:0]       cfg_data,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire                             operation,
	input  wire  [tnm_pkg::COORD_W-1:0]     pixel_x,
	input  wire  [tnm_pkg::COORD_W-1:0]     pixel_y,
	input  wire  [tnm_pkg::CHAN_W-1:0]      red,
	input  wire  [tnm_pkg::CHAN_W-1:0]      green,
	input  wire  [tnm_pkg::CHAN_W-1:0]      blue,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic [tnm_pkg::SLOPE_W-1:0]     normal_x,
	output logic [tnm_pkg::SLOPE_W-1:0]     normal_y,
	output logic                            bad_coordinate
);
	import tnm_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer
	tnm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// store and arithmetic
	tnm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.operation      (operation),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.cmd            (cmd),
		.status         (status),
		.normal_x       (normal_x),
		.normal_y       (normal_y),
		.bad_coordinate (bad_coordinate)
	);

`ifndef NO_ASSERTIONS
	// a new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid || !out_stall))
		else $error("result register overwritten while stalled");

	// store reads only while a query is held
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> in_stall)
		else $error("store read with no query held");

	// flagged queries report a flat normal
	a_bad_flat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_coordinate) |-> (normal_x == SLOPE_FLAT && normal_y == SLOPE_FLAT))
		else $error("out-of-image query with a non-flat normal");

	// a fresh result follows a finished query
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.load_out))
		else $error("result appeared without a load");
`endif

endmodule
`default_nettype wire
